// ===== hdl/ogi_pkg.sv =====
package ogi_pkg;

  localparam int GAMMA_WORDS  = 21;
  localparam int GAMMA_LEVELS = 9;
  localparam int LEVEL_STEP   = 30;

  typedef logic [3:0]  level_t;
  typedef logic [4:0]  word_t;
  typedef logic [4:0]  frac_t;
  typedef logic [11:0] mix_t;

  localparam logic [7:0] BRIGHT_MIN       = 8'd10;
  localparam logic [7:0] BRIGHT_MAX       = 8'd250;
  localparam logic [7:0] BRIGHT_LOW_LIMIT = 8'd31;
  localparam logic [7:0] BRIGHT_LOW_VALUE = 8'd20;

  localparam level_t LAST_LEVEL = level_t'(GAMMA_LEVELS - 1);
  localparam word_t  LAST_WORD  = word_t'(GAMMA_WORDS - 1);
  localparam frac_t  STEP       = frac_t'(LEVEL_STEP);

  // floor(d / 30) for d <= 240 is (d * 274) >> 13
  localparam logic [10:0] LEVEL_RECIP = 11'd274;
  localparam int          LEVEL_SHIFT = 13;
  // (s * 1092) >> 15 is floor(s / 30) or one less for s < 4096
  localparam logic [10:0] MIX_RECIP   = 11'd1092;
  localparam int          MIX_SHIFT   = 15;

  localparam logic [6:0] BANK_REG  = 7'h39;
  localparam logic [7:0] BANK_VAL0 = 8'h43;
  localparam logic [7:0] BANK_VAL1 = 8'h34;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEVEL,
    S_SPLIT,
    S_MUL_A,
    S_MUL_B,
    S_RECIP,
    S_CORR,
    S_BANK,
    S_EMIT
  } state_t;

  typedef struct packed {
    state_t state;
    word_t  word;
    logic   bank_phase;
  } ctrl_t;

  typedef struct packed {
    logic        en;
    logic [11:0] x;
    logic [10:0] y;
    logic [23:0] z;
  } mac_op_t;

  localparam logic [6:0] WORD_ADDR [0:GAMMA_WORDS-1] = '{
    7'h40, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
    7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56,
    7'h60, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };

  localparam logic [7:0] GAMMA_ROM [0:GAMMA_LEVELS-1][0:GAMMA_WORDS-1] = '{
    '{8'h00, 8'h3f, 8'h40, 8'h39, 8'h32, 8'h2e, 8'h0c, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h26, 8'h2d, 8'h0b, 8'h00, 8'h3f, 8'h40, 8'h38, 8'h31, 8'h2d, 8'h12},
    '{8'h00, 8'h3f, 8'h3e, 8'h2e, 8'h2d, 8'h28, 8'h21, 8'h00, 8'h00, 8'h00, 8'h21,
      8'h2a, 8'h28, 8'h20, 8'h00, 8'h3f, 8'h3e, 8'h2d, 8'h2b, 8'h26, 8'h2d},
    '{8'h00, 8'h3f, 8'h35, 8'h2c, 8'h2b, 8'h26, 8'h29, 8'h00, 8'h00, 8'h00, 8'h25,
      8'h29, 8'h26, 8'h28, 8'h00, 8'h3f, 8'h34, 8'h2b, 8'h2a, 8'h23, 8'h37},
    '{8'h00, 8'h3f, 8'h30, 8'h2a, 8'h2b, 8'h24, 8'h2f, 8'h00, 8'h00, 8'h00, 8'h25,
      8'h29, 8'h24, 8'h2e, 8'h00, 8'h3f, 8'h2f, 8'h29, 8'h29, 8'h21, 8'h3f},
    '{8'h00, 8'h3f, 8'h2e, 8'h29, 8'h2a, 8'h23, 8'h34, 8'h00, 8'h00, 8'h0a, 8'h25,
      8'h28, 8'h23, 8'h33, 8'h00, 8'h3f, 8'h2d, 8'h28, 8'h27, 8'h20, 8'h46},
    '{8'h00, 8'h3f, 8'h2b, 8'h29, 8'h28, 8'h23, 8'h38, 8'h00, 8'h00, 8'h0b, 8'h25,
      8'h27, 8'h23, 8'h37, 8'h00, 8'h3f, 8'h29, 8'h28, 8'h25, 8'h20, 8'h4b},
    '{8'h00, 8'h3f, 8'h29, 8'h29, 8'h27, 8'h22, 8'h3c, 8'h00, 8'h00, 8'h10, 8'h26,
      8'h26, 8'h22, 8'h3b, 8'h00, 8'h3f, 8'h28, 8'h28, 8'h24, 8'h1f, 8'h50},
    '{8'h00, 8'h3f, 8'h28, 8'h28, 8'h28, 8'h20, 8'h40, 8'h00, 8'h00, 8'h11, 8'h25,
      8'h27, 8'h20, 8'h3f, 8'h00, 8'h3f, 8'h27, 8'h26, 8'h26, 8'h1c, 8'h56},
    '{8'h00, 8'h3f, 8'h2a, 8'h27, 8'h27, 8'h1f, 8'h44, 8'h00, 8'h00, 8'h17, 8'h24,
      8'h26, 8'h1f, 8'h43, 8'h00, 8'h3f, 8'h2a, 8'h25, 8'h24, 8'h1b, 8'h5c}
  };

endpackage

// ===== hdl/ogi_mac.sv =====
module ogi_mac (
  input  logic              clk,
  input  ogi_pkg::mac_op_t  op,
  output logic [23:0]       acc
);

  // shared multiply-add, one operation per cycle, registered result
  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= 24'(op.x) * 24'(op.y) + op.z;
    end
  end

endmodule

// ===== hdl/ogi_ctrl.sv =====
module ogi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output ogi_pkg::ctrl_t    ctrl
);

  ogi_pkg::state_t state;
  ogi_pkg::state_t state_next;
  ogi_pkg::word_t  word;
  ogi_pkg::word_t  word_next;
  logic            bank_phase;
  logic            bank_phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ogi_pkg::S_IDLE;
      word       <= '0;
      bank_phase <= 1'b0;
    end else begin
      state      <= state_next;
      word       <= word_next;
      bank_phase <= bank_phase_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ogi_pkg::S_IDLE:  if (in_valid) state_next = ogi_pkg::S_LEVEL;
      ogi_pkg::S_LEVEL: state_next = ogi_pkg::S_SPLIT;
      ogi_pkg::S_SPLIT: state_next = ogi_pkg::S_MUL_A;
      ogi_pkg::S_MUL_A: state_next = ogi_pkg::S_MUL_B;
      ogi_pkg::S_MUL_B: state_next = ogi_pkg::S_RECIP;
      ogi_pkg::S_RECIP: state_next = ogi_pkg::S_CORR;
      ogi_pkg::S_CORR:  state_next = ogi_pkg::S_EMIT;
      ogi_pkg::S_BANK:  state_next = ogi_pkg::S_EMIT;
      ogi_pkg::S_EMIT: begin
        if (out_ready) begin
          if (bank_phase) begin
            state_next = ogi_pkg::S_IDLE;
          end else if (word == ogi_pkg::LAST_WORD) begin
            state_next = ogi_pkg::S_BANK;
          end else begin
            state_next = ogi_pkg::S_MUL_A;
          end
        end
      end
      default: state_next = ogi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    word_next       = word;
    bank_phase_next = bank_phase;
    case (state)
      ogi_pkg::S_IDLE: begin
        word_next       = '0;
        bank_phase_next = 1'b0;
      end
      ogi_pkg::S_BANK: bank_phase_next = 1'b1;
      ogi_pkg::S_EMIT: begin
        if (out_ready && !bank_phase && word != ogi_pkg::LAST_WORD) begin
          word_next = word + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    in_ready        = (state == ogi_pkg::S_IDLE);
    out_valid       = (state == ogi_pkg::S_EMIT);
    ctrl.state      = state;
    ctrl.word       = word;
    ctrl.bank_phase = bank_phase;
  end

endmodule

// ===== hdl/oled_gamma_interpolator.sv =====
// Turns one brightness request into a burst of 22 panel register writes: 21
// gamma words (interpolated between two rows of the built-in 9-row ROM) and a
// final bank select write flagged by last. One request is worked at a time;
// in_ready is low from acceptance until the bank select transaction is taken.
// A single shared multiply-add unit does all multiplications; each gamma word
// passes through five states (two products, a reciprocal multiply, a correction
// step, the output slot), and the output slot waits for out_ready.
module oled_gamma_interpolator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] brightness,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] reg_addr,
  output logic [7:0] reg_value,
  output logic       last
);

  ogi_pkg::ctrl_t   ctrl;
  ogi_pkg::mac_op_t mac_op;
  logic [23:0]      acc;

  logic [7:0]       d;
  ogi_pkg::level_t  level;
  ogi_pkg::frac_t   frac;
  ogi_pkg::mix_t    s_hold;
  logic             bank;

  logic [7:0]       v_lim;
  logic [7:0]       v_even;
  logic [7:0]       v_adj;
  ogi_pkg::level_t  split_level;
  logic [8:0]       split_lvl30;
  logic [8:0]       split_diff;
  ogi_pkg::level_t  level_up;
  logic [7:0]       row_a;
  logic [7:0]       row_b;
  logic [6:0]       q0;
  ogi_pkg::mix_t    q0_30;
  ogi_pkg::mix_t    rem;
  logic [7:0]       mix_value;

  ogi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  ogi_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  // request clamp, rounding down to even, and low-end override
  always_comb begin
    if (brightness < ogi_pkg::BRIGHT_MIN) begin
      v_lim = ogi_pkg::BRIGHT_MIN;
    end else if (brightness > ogi_pkg::BRIGHT_MAX) begin
      v_lim = ogi_pkg::BRIGHT_MAX;
    end else begin
      v_lim = brightness;
    end
    v_even = {v_lim[7:1], 1'b0};
    v_adj  = (v_even < ogi_pkg::BRIGHT_LOW_LIMIT) ? ogi_pkg::BRIGHT_LOW_VALUE : v_even;
  end

  // level and fraction from the reciprocal product
  always_comb begin
    split_level = acc[ogi_pkg::LEVEL_SHIFT +: 4];
    split_lvl30 = {split_level, 5'b0} - {4'b0, split_level, 1'b0};
    split_diff  = {1'b0, d} - split_lvl30;
  end

  always_comb begin
    level_up = (level == ogi_pkg::LAST_LEVEL) ? level : level + 1'b1;
    row_a    = ogi_pkg::GAMMA_ROM[level][ctrl.word];
    row_b    = ogi_pkg::GAMMA_ROM[level_up][ctrl.word];
  end

  // quotient estimate is exact or one short
  always_comb begin
    q0        = acc[ogi_pkg::MIX_SHIFT +: 7];
    q0_30     = {q0, 5'b0} - {4'b0, q0, 1'b0};
    rem       = s_hold - q0_30;
    mix_value = (rem >= 12'(ogi_pkg::STEP)) ? {1'b0, q0} + 8'd1 : {1'b0, q0};
  end

  always_comb begin
    mac_op.en = 1'b0;
    mac_op.x  = '0;
    mac_op.y  = '0;
    mac_op.z  = '0;
    case (ctrl.state)
      ogi_pkg::S_LEVEL: begin
        mac_op.en = 1'b1;
        mac_op.x  = {4'b0, d};
        mac_op.y  = ogi_pkg::LEVEL_RECIP;
      end
      ogi_pkg::S_MUL_A: begin
        mac_op.en = 1'b1;
        mac_op.x  = {4'b0, row_a};
        mac_op.y  = {6'b0, ogi_pkg::STEP - frac};
      end
      ogi_pkg::S_MUL_B: begin
        mac_op.en = 1'b1;
        mac_op.x  = {4'b0, row_b};
        mac_op.y  = {6'b0, frac};
        mac_op.z  = acc;
      end
      ogi_pkg::S_RECIP: begin
        mac_op.en = 1'b1;
        mac_op.x  = acc[11:0];
        mac_op.y  = ogi_pkg::MIX_RECIP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d <= v_adj - ogi_pkg::BRIGHT_MIN;
    end
    if (ctrl.state == ogi_pkg::S_SPLIT) begin
      level <= split_level;
      frac  <= (split_level == ogi_pkg::LAST_LEVEL) ? '0 : split_diff[4:0];
    end
    if (ctrl.state == ogi_pkg::S_RECIP) begin
      s_hold <= acc[11:0];
    end
    if (ctrl.state == ogi_pkg::S_CORR) begin
      reg_addr  <= ogi_pkg::WORD_ADDR[ctrl.word];
      reg_value <= mix_value;
      last      <= 1'b0;
    end
    if (ctrl.state == ogi_pkg::S_BANK) begin
      reg_addr  <= ogi_pkg::BANK_REG;
      reg_value <= bank ? ogi_pkg::BANK_VAL1 : ogi_pkg::BANK_VAL0;
      last      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
    end else if (out_valid && out_ready && last) begin
      bank <= ~bank;
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_last_is_bank: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (reg_addr == ogi_pkg::BANK_REG))
    else $error("last transaction is not the bank select");

  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result shown right after request");

  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (bank != $past(bank)))
    else $error("bank bit did not flip after the run");

  a_word_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (ctrl.word <= ogi_pkg::LAST_WORD))
    else $error("gamma word index out of range");

endmodule
